// ----- src/lattice_site_grid_binner_core_assert.svh -----
// ----------------------------------------------------------------------------
// lattice_site_grid_binner_core_assert.svh
// Assertion macros used by the grid binner core. The module that uses them
// provides signals named clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef LATTICE_SITE_GRID_BINNER_CORE_ASSERT_SVH
`define LATTICE_SITE_GRID_BINNER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset
`define LSGB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lattice_site_grid_binner_core: check failed");

// Next-cycle implication, masked during reset
`define LSGB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lattice_site_grid_binner_core: check failed");

`endif

// ----- src/lsgb_pkg.sv -----
// ----------------------------------------------------------------------------
// lsgb_pkg
// Types and constants of the lattice site grid binner.
// ----------------------------------------------------------------------------
package lsgb_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_OFF_GRID    = 3'd1,
		ST_OFF_LATTICE = 3'd2,
		ST_RANGE       = 3'd3,
		ST_COLLISION   = 3'd4,
		ST_FAILED      = 3'd5
	} status_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_SCALE_IN_PLANE = 3'd0,
		CFG_SCALE_VERTICAL = 3'd1,
		CFG_GRID_DIM_X     = 3'd2,
		CFG_GRID_DIM_Y     = 3'd3,
		CFG_GRID_DIM_Z     = 3'd4
	} cfg_idx_t;

	// Request actions
	localparam logic ACTION_CLEAR = 1'b0;
	localparam logic ACTION_PLACE = 1'b1;

	// Register reset values
	localparam logic [23:0] SCALE_RESET = 24'd65536;
	localparam logic [10:0] DIM_RESET   = 11'd1;

	// Quarter-cell tolerance on the Q.32 fraction
	localparam logic [31:0] FRAC_QUARTER = 32'h4000_0000;
	localparam logic [31:0] FRAC_THREE_Q = 32'hC000_0000;

	// Coordinate range after rounding
	localparam logic signed [26:0] COORD_MIN = -27'sd32768;
	localparam logic signed [26:0] COORD_MAX = 27'sd32767;

	// Magnitude width seen by the remainder unit
	localparam int unsigned MAG_W = 16;
	localparam int unsigned MAG_CW = $clog2(MAG_W);

	typedef struct packed {
		logic               action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic        [15:0] site_number;
		logic signed [15:0] coord_i;
		logic signed [15:0] coord_j;
		logic signed [15:0] coord_k;
		logic        [15:0] cell_index;
		status_t            status;
	} out_item_t;

	// Request to a remainder lane
	typedef struct packed {
		logic             start;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [10:0]      modulus;
	} mod_req_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_ABS,
		S_MUL,
		S_RND,
		S_CHK,
		S_WRAP,
		S_IX1,
		S_IX2,
		S_RD,
		S_COL,
		S_FIN,
		S_CFIN
	} state_t;

endpackage

// ----- src/lsgb_mod.sv -----
// ----------------------------------------------------------------------------
// lsgb_mod
// Bit-serial remainder lane: wraps a signed coordinate into 0..n-1,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lsgb_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  lsgb_pkg::mod_req_t req,
	output logic              done,
	output logic [10:0]       rem
);

	logic                          busy_q;
	logic                          done_q;
	logic [lsgb_pkg::MAG_CW-1:0]   cnt_q;
	logic [lsgb_pkg::MAG_W-1:0]    dvd_q;
	logic [10:0]                   rem_q;
	logic [10:0]                   n_q;
	logic                          neg_q;
	logic [11:0]                   trial;
	logic [11:0]                   trial_sub;
	logic [10:0]                   rem_nx;

	// One restoring step
	always_comb begin
		trial     = {rem_q, dvd_q[lsgb_pkg::MAG_W-1]};
		trial_sub = trial - {1'b0, n_q};
		if (trial >= {1'b0, n_q}) begin
			rem_nx = trial_sub[10:0];
		end else begin
			rem_nx = trial[10:0];
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == lsgb_pkg::MAG_CW'(lsgb_pkg::MAG_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.mag;
			rem_q <= '0;
			n_q   <= req.modulus;
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[lsgb_pkg::MAG_W-2:0], 1'b0};
		end
	end

	// Fold negative values back into range
	assign rem  = (neg_q && rem_q != 11'd0) ? (n_q - rem_q) : rem_q;
	assign done = done_q;

endmodule

// ----- src/lsgb_occ.sv -----
// ----------------------------------------------------------------------------
// lsgb_occ
// Cell occupancy memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lsgb_occ #(
	parameter int unsigned DEPTH = 65536,
	parameter int unsigned AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/lattice_site_grid_binner_core.sv -----
// Sequence: a place request runs three serial scale multiplies, a 16-step
//   remainder, two index multiplies, an occupancy read and check, and stops
//   early on a failed check or an earlier failure; a clear request skips them.
// Flow: one request at a time; the next is taken once the last result is loaded.
// Reset and clear: the occupancy memory is swept one cell per cycle, during which
//   no request is accepted; configuration writes still land.
// ----------------------------------------------------------------------------
// lattice_site_grid_binner_core
// Snaps atom positions to a same-parity grid, wraps them into a flat cell
// index and tracks cell occupancy in a single-port-per-direction memory.
// ----------------------------------------------------------------------------
`include "lattice_site_grid_binner_core_assert.svh"

module lattice_site_grid_binner_core #(
	parameter int unsigned MAX_CELLS = 65536,
	parameter int unsigned MAX_SITES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lsgb_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lsgb_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data
);

	localparam int unsigned AW = $clog2(MAX_CELLS);
	localparam int unsigned SW = $clog2(MAX_SITES + 1);

	lsgb_pkg::state_t st_q, st_d;

	// Configuration
	logic [23:0] scale_ip_q, scale_v_q;
	logic [10:0] dim_x_q, dim_y_q, dim_z_q;
	logic [10:0] nx, ny, nz;

	// Build state
	logic signed [31:0] org_q [3];
	logic [SW-1:0]      sites_q;
	logic               failed_q;

	// Per-request datapath
	logic signed [31:0] pos_q [3];
	logic [1:0]         ax_q;
	logic [32:0]        mag_q;
	logic               neg_q;
	logic [56:0]        prod_q;
	logic signed [26:0] r_q [3];
	logic               offgrid_q;
	lsgb_pkg::status_t  status_q;
	logic [21:0]        t1_q;
	logic [33:0]        cell_q;
	logic [15:0]        site_num_q;
	logic [AW-1:0]      clr_q;

	// Output register
	logic                out_valid_q;
	lsgb_pkg::out_item_t out_q;

	// Internal control
	logic               acc;
	logic               ld;
	logic               cell_ok;
	logic signed [32:0] d;
	logic [32:0]        mag_d;
	logic [23:0]        scale_sel;
	logic [25:0]        rmag;
	logic signed [26:0] r_val;
	logic               snap_ok;
	logic               par_bad;
	logic               rng_bad;
	lsgb_pkg::mod_req_t mreq [3];
	logic [10:0]        wrem [3];
	logic               mdone [3];
	logic               mem_we, mem_wd, mem_re, occ_rd;
	logic [AW-1:0]      mem_wa;
	logic               out_zero;

	// Zero dimensions act as one
	assign nx = (dim_x_q == 11'd0) ? 11'd1 : dim_x_q;
	assign ny = (dim_y_q == 11'd0) ? 11'd1 : dim_y_q;
	assign nz = (dim_z_q == 11'd0) ? 11'd1 : dim_z_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_ip_q <= lsgb_pkg::SCALE_RESET;
			scale_v_q  <= lsgb_pkg::SCALE_RESET;
			dim_x_q    <= lsgb_pkg::DIM_RESET;
			dim_y_q    <= lsgb_pkg::DIM_RESET;
			dim_z_q    <= lsgb_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lsgb_pkg::CFG_SCALE_IN_PLANE: scale_ip_q <= cfg_data;
				lsgb_pkg::CFG_SCALE_VERTICAL: scale_v_q  <= cfg_data;
				lsgb_pkg::CFG_GRID_DIM_X:     dim_x_q    <= cfg_data[10:0];
				lsgb_pkg::CFG_GRID_DIM_Y:     dim_y_q    <= cfg_data[10:0];
				lsgb_pkg::CFG_GRID_DIM_Z:     dim_z_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Offset and magnitude for the current axis
	always_comb begin
		d     = {pos_q[ax_q][31], pos_q[ax_q]} - {org_q[ax_q][31], org_q[ax_q]};
		mag_d = d[32] ? 33'(-d) : 33'(d);
	end

	assign scale_sel = (ax_q == 2'd2) ? scale_v_q : scale_ip_q;

	// Round half away from zero, keep within a quarter cell
	always_comb begin
		rmag    = 26'(prod_q[56:32]) + 26'(prod_q[31]);
		r_val   = neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
		snap_ok = (prod_q[31:0] <= lsgb_pkg::FRAC_QUARTER) ||
		          (prod_q[31:0] >= lsgb_pkg::FRAC_THREE_Q);
	end

	// Sublattice and range checks
	always_comb begin
		par_bad = (r_q[0][0] ^ r_q[1][0]) | (r_q[1][0] ^ r_q[2][0]);
		rng_bad = (sites_q >= SW'(MAX_SITES));
		for (int a = 0; a < 3; a++) begin
			if (r_q[a] < lsgb_pkg::COORD_MIN || r_q[a] > lsgb_pkg::COORD_MAX) begin
				rng_bad = 1'b1;
			end
		end
	end

	// Remainder lane requests
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mreq[a].start = (st_q == lsgb_pkg::S_CHK) && !offgrid_q && !par_bad && !rng_bad;
			mreq[a].neg   = r_q[a][26];
			mreq[a].mag   = r_q[a][26] ? lsgb_pkg::MAG_W'(-r_q[a])
			                           : lsgb_pkg::MAG_W'(r_q[a]);
		end
		mreq[0].modulus = nx;
		mreq[1].modulus = ny;
		mreq[2].modulus = nz;
	end

	for (genvar g = 0; g < 3; g++) begin : g_mod
		lsgb_mod u_mod (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (mreq[g]),
			.done   (mdone[g]),
			.rem    (wrem[g])
		);
	end

	// Occupancy memory access
	assign cell_ok = (cell_q < 34'(MAX_CELLS));
	assign mem_re  = (st_q == lsgb_pkg::S_RD) && cell_ok;
	assign mem_we  = (st_q == lsgb_pkg::S_CLR) || ((st_q == lsgb_pkg::S_COL) && !occ_rd);
	assign mem_wa  = (st_q == lsgb_pkg::S_CLR) ? clr_q : cell_q[AW-1:0];
	assign mem_wd  = (st_q != lsgb_pkg::S_CLR);

	lsgb_occ #(
		.DEPTH (MAX_CELLS),
		.AW    (AW)
	) u_occ (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.re    (mem_re),
		.raddr (cell_q[AW-1:0]),
		.rdata (occ_rd)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lsgb_pkg::S_CLR;
		end else begin
			st_q <= st_d;
		end
	end

	// Next state and handshake
	always_comb begin
		st_d     = st_q;
		in_stall = (st_q != lsgb_pkg::S_IDLE);
		acc      = in_valid && !in_stall;
		ld       = ((st_q == lsgb_pkg::S_FIN) || (st_q == lsgb_pkg::S_CFIN)) &&
		           (!out_valid_q || !out_stall);
		case (st_q)
			lsgb_pkg::S_CLR: begin
				if (clr_q == AW'(MAX_CELLS - 1)) st_d = lsgb_pkg::S_IDLE;
			end
			lsgb_pkg::S_IDLE: begin
				if (acc) begin
					if (in_data.action == lsgb_pkg::ACTION_CLEAR) st_d = lsgb_pkg::S_CFIN;
					else if (failed_q) st_d = lsgb_pkg::S_FIN;
					else st_d = lsgb_pkg::S_ABS;
				end
			end
			lsgb_pkg::S_ABS: st_d = lsgb_pkg::S_MUL;
			lsgb_pkg::S_MUL: st_d = lsgb_pkg::S_RND;
			lsgb_pkg::S_RND: st_d = (ax_q == 2'd2) ? lsgb_pkg::S_CHK : lsgb_pkg::S_ABS;
			lsgb_pkg::S_CHK: begin
				if (offgrid_q || par_bad || rng_bad) st_d = lsgb_pkg::S_FIN;
				else st_d = lsgb_pkg::S_WRAP;
			end
			lsgb_pkg::S_WRAP: begin
				if (mdone[0] && mdone[1] && mdone[2]) st_d = lsgb_pkg::S_IX1;
			end
			lsgb_pkg::S_IX1: st_d = lsgb_pkg::S_IX2;
			lsgb_pkg::S_IX2: st_d = lsgb_pkg::S_RD;
			lsgb_pkg::S_RD:  st_d = cell_ok ? lsgb_pkg::S_COL : lsgb_pkg::S_FIN;
			lsgb_pkg::S_COL: st_d = lsgb_pkg::S_FIN;
			lsgb_pkg::S_FIN: begin
				if (ld) st_d = lsgb_pkg::S_IDLE;
			end
			lsgb_pkg::S_CFIN: begin
				if (ld) st_d = lsgb_pkg::S_CLR;
			end
			default: st_d = lsgb_pkg::S_CLR;
		endcase
	end

	// Build state: counter, failure flag, sweep pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sites_q  <= '0;
			failed_q <= 1'b0;
			clr_q    <= '0;
		end else begin
			if (st_q == lsgb_pkg::S_CLR) begin
				clr_q <= (clr_q == AW'(MAX_CELLS - 1)) ? '0 : clr_q + 1'b1;
			end
			if (acc && in_data.action == lsgb_pkg::ACTION_CLEAR) begin
				sites_q  <= '0;
				failed_q <= 1'b0;
			end else if (ld && st_q == lsgb_pkg::S_FIN) begin
				if (status_q == lsgb_pkg::ST_OK) sites_q <= sites_q + 1'b1;
				else failed_q <= 1'b1;
			end
		end
	end

	// Origin: reset to zero, cleared by a clear request, loaded by the first placement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) org_q[a] <= '0;
		end else if (acc) begin
			if (in_data.action == lsgb_pkg::ACTION_CLEAR) begin
				for (int a = 0; a < 3; a++) org_q[a] <= '0;
			end else if (!failed_q && sites_q == '0) begin
				org_q[0] <= in_data.pos_x;
				org_q[1] <= in_data.pos_y;
				org_q[2] <= in_data.pos_z;
			end
		end
	end

	// Per-request datapath
	always_ff @(posedge clk) begin
		case (st_q)
			lsgb_pkg::S_IDLE: begin
				pos_q[0]   <= in_data.pos_x;
				pos_q[1]   <= in_data.pos_y;
				pos_q[2]   <= in_data.pos_z;
				ax_q       <= 2'd0;
				offgrid_q  <= 1'b0;
				site_num_q <= 16'(sites_q);
				status_q   <= failed_q ? lsgb_pkg::ST_FAILED : lsgb_pkg::ST_OK;
			end
			lsgb_pkg::S_ABS: begin
				mag_q <= mag_d;
				neg_q <= d[32];
			end
			lsgb_pkg::S_MUL: prod_q <= 57'(mag_q) * 57'(scale_sel);
			lsgb_pkg::S_RND: begin
				r_q[ax_q] <= r_val;
				offgrid_q <= offgrid_q | !snap_ok;
				ax_q      <= ax_q + 2'd1;
			end
			lsgb_pkg::S_CHK: begin
				if (offgrid_q) status_q <= lsgb_pkg::ST_OFF_GRID;
				else if (par_bad) status_q <= lsgb_pkg::ST_OFF_LATTICE;
				else if (rng_bad) status_q <= lsgb_pkg::ST_RANGE;
			end
			lsgb_pkg::S_IX1: t1_q <= 22'(wrem[0]) * 22'(ny) + 22'(wrem[1]);
			lsgb_pkg::S_IX2: cell_q <= 34'(t1_q) * 34'(nz) + 34'(wrem[2]);
			lsgb_pkg::S_RD: begin
				if (!cell_ok) status_q <= lsgb_pkg::ST_RANGE;
			end
			lsgb_pkg::S_COL: begin
				if (occ_rd) status_q <= lsgb_pkg::ST_COLLISION;
			end
			default: ;
		endcase
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_q <= '0;
			if (st_q == lsgb_pkg::S_FIN) begin
				out_q.site_number <= site_num_q;
				out_q.status      <= status_q;
				if (status_q == lsgb_pkg::ST_OK) begin
					out_q.coord_i    <= 16'(r_q[0]);
					out_q.coord_j    <= 16'(r_q[1]);
					out_q.coord_k    <= 16'(r_q[2]);
					out_q.cell_index <= 16'(cell_q);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Coordinates and index of the held result are all zero
	assign out_zero = (out_q.coord_i == '0) && (out_q.coord_j == '0) &&
	                  (out_q.coord_k == '0) && (out_q.cell_index == '0);

	`LSGB_ASSERT_IMP(a_sweep_zero, st_q == lsgb_pkg::S_CLR, mem_we && !mem_wd)
	`LSGB_ASSERT_IMP(a_err_zero, out_valid_q && out_q.status != lsgb_pkg::ST_OK, out_zero)
	`LSGB_ASSERT_NXT(a_count_ok, ld && st_q == lsgb_pkg::S_FIN && status_q == lsgb_pkg::ST_OK, sites_q == $past(sites_q) + SW'(1))
	`LSGB_ASSERT_NXT(a_fail_sticky, failed_q && !(acc && in_data.action == lsgb_pkg::ACTION_CLEAR), failed_q)

endmodule

// ----- verif/tb_lattice_site_grid_binner_core.sv -----
// ----------------------------------------------------------------------------
// tb_lattice_site_grid_binner_core
// Self-checking bench for the grid binner. A scoreboard class tracks the
// origin, site count, sticky failure and cell occupancy. It predicts one
// result for each accepted request and checks the results in order. The
// stimulus starts with a short directed part. After that come phases of
// well-formed placements under several register settings, each broken by one
// fault near its end and followed by random noise. Both sides idle at random except in the third phase.
// ----------------------------------------------------------------------------
module tb_lattice_site_grid_binner_core;

	typedef enum int {
		FAULT_NONE,
		FAULT_OFF_GRID,
		FAULT_PARITY,
		FAULT_RANGE,
		FAULT_REPEAT
	} fault_t;

	// Predicts binner results and checks them in arrival order
	class site_binner_scoreboard;
		bit [23:0]             scale_xy;
		bit [23:0]             scale_z;
		bit [10:0]             dim_x;
		bit [10:0]             dim_y;
		bit [10:0]             dim_z;
		bit                    occupied [65536];
		longint                origin [3];
		int unsigned           placed;
		bit                    failed;
		lsgb_pkg::out_item_t   expected_q [$];
		int unsigned           errors;

		function new();
			scale_xy = lsgb_pkg::SCALE_RESET;
			scale_z  = lsgb_pkg::SCALE_RESET;
			dim_x    = lsgb_pkg::DIM_RESET;
			dim_y    = lsgb_pkg::DIM_RESET;
			dim_z    = lsgb_pkg::DIM_RESET;
			empty_grid();
			errors   = 0;
		endfunction

		function void empty_grid();
			foreach (occupied[n])
				occupied[n] = 1'b0;
			origin[0] = 0;
			origin[1] = 0;
			origin[2] = 0;
			placed    = 0;
			failed    = 1'b0;
		endfunction

		function void write_reg(lsgb_pkg::cfg_idx_t idx, bit [23:0] value);
			case (idx)
				lsgb_pkg::CFG_SCALE_IN_PLANE: scale_xy = value;
				lsgb_pkg::CFG_SCALE_VERTICAL: scale_z  = value;
				lsgb_pkg::CFG_GRID_DIM_X:     dim_x    = value[10:0];
				lsgb_pkg::CFG_GRID_DIM_Y:     dim_y    = value[10:0];
				lsgb_pkg::CFG_GRID_DIM_Z:     dim_z    = value[10:0];
				default: ;
			endcase
		endfunction

		// Round half away from zero; ok clear when more than a quarter cell off
		function void snap(longint d, bit [23:0] sc, output longint r, output bit ok);
			longint unsigned mag;
			longint unsigned prod;
			longint unsigned rm;
			longint unsigned base;
			longint unsigned err;
			mag  = (d < 0) ? longint'(-d) : d;
			prod = mag * longint'(sc);
			rm   = (prod + 64'h8000_0000) >> 32;
			base = rm << 32;
			err  = (prod >= base) ? prod - base : base - prod;
			r    = (d < 0) ? -longint'(rm) : longint'(rm);
			ok   = (err <= 64'h4000_0000);
		endfunction

		function longint wrap(longint r, bit [10:0] dim);
			longint n;
			n = (dim == 0) ? 1 : longint'(dim);
			return ((r % n) + n) % n;
		endfunction

		function longint flat_cell(longint ri, longint rj, longint rk);
			longint ny;
			longint nz;
			ny = (dim_y == 0) ? 1 : longint'(dim_y);
			nz = (dim_z == 0) ? 1 : longint'(dim_z);
			return (wrap(ri, dim_x) * ny + wrap(rj, dim_y)) * nz + wrap(rk, dim_z);
		endfunction

		function void note_request(lsgb_pkg::in_item_t req);
			lsgb_pkg::out_item_t exp;
			longint              pos [3];
			longint              r [3];
			bit                  ok;
			lsgb_pkg::status_t   st;
			longint              cell_ix;
			exp     = '0;
			st      = lsgb_pkg::ST_OK;
			cell_ix = 0;
			if (req.action == lsgb_pkg::ACTION_CLEAR) begin
				empty_grid();
				expected_q.push_back(exp);
				return;
			end
			exp.site_number = placed[15:0];
			if (failed) begin
				exp.status = lsgb_pkg::ST_FAILED;
				expected_q.push_back(exp);
				return;
			end
			pos[0] = longint'($signed(req.pos_x));
			pos[1] = longint'($signed(req.pos_y));
			pos[2] = longint'($signed(req.pos_z));
			if (placed == 0) begin
				origin[0] = pos[0];
				origin[1] = pos[1];
				origin[2] = pos[2];
			end
			for (int a = 0; a < 3; a++) begin
				snap(pos[a] - origin[a], (a == 2) ? scale_z : scale_xy, r[a], ok);
				if (!ok)
					st = lsgb_pkg::ST_OFF_GRID;
			end
			if (st == lsgb_pkg::ST_OK &&
			    (((r[0] ^ r[1]) & 1) != 0 || ((r[1] ^ r[2]) & 1) != 0))
				st = lsgb_pkg::ST_OFF_LATTICE;
			if (st == lsgb_pkg::ST_OK) begin
				for (int a = 0; a < 3; a++)
					if (r[a] < -32768 || r[a] > 32767)
						st = lsgb_pkg::ST_RANGE;
				if (placed >= 65536)
					st = lsgb_pkg::ST_RANGE;
			end
			if (st == lsgb_pkg::ST_OK) begin
				cell_ix = flat_cell(r[0], r[1], r[2]);
				if (cell_ix >= 65536)
					st = lsgb_pkg::ST_RANGE;
				else if (occupied[cell_ix])
					st = lsgb_pkg::ST_COLLISION;
			end
			if (st != lsgb_pkg::ST_OK) begin
				failed     = 1'b1;
				exp.status = st;
			end else begin
				occupied[cell_ix] = 1'b1;
				placed++;
				exp.coord_i    = r[0][15:0];
				exp.coord_j    = r[1][15:0];
				exp.coord_k    = r[2][15:0];
				exp.cell_index = cell_ix[15:0];
			end
			expected_q.push_back(exp);
		endfunction

		function void check_result(lsgb_pkg::out_item_t got);
			lsgb_pkg::out_item_t exp;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			if (got.site_number !== exp.site_number) begin
				$display("%0t: site_number expected %0d actual %0d", $time,
					exp.site_number, got.site_number);
				errors++;
			end
			if (got.coord_i !== exp.coord_i) begin
				$display("%0t: coord_i expected %0d actual %0d", $time, exp.coord_i, got.coord_i);
				errors++;
			end
			if (got.coord_j !== exp.coord_j) begin
				$display("%0t: coord_j expected %0d actual %0d", $time, exp.coord_j, got.coord_j);
				errors++;
			end
			if (got.coord_k !== exp.coord_k) begin
				$display("%0t: coord_k expected %0d actual %0d", $time, exp.coord_k, got.coord_k);
				errors++;
			end
			if (got.cell_index !== exp.cell_index) begin
				$display("%0t: cell_index expected %0d actual %0d", $time,
					exp.cell_index, got.cell_index);
				errors++;
			end
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	lsgb_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall;
	lsgb_pkg::out_item_t out_data;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [23:0]         cfg_data;

	site_binner_scoreboard sb;
	bit     idle_on;
	bit     hold_req;
	bit     gen_used [65536];
	longint gen_origin [3];
	longint last_c [3];

	lattice_site_grid_binner_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Bound the run
	initial begin
		#36000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Drain results with random stalls and one long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (int n = 0; n < 600; n++)
					@(negedge clk);
				hold_req = 1'b0;
			end
			out_stall <= idle_on && ($urandom_range(99) < 37);
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
		end
	end

	task automatic send_request(lsgb_pkg::in_item_t req);
		@(negedge clk);
		if (idle_on && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(req);
	endtask

	task automatic write_reg(lsgb_pkg::cfg_idx_t idx, bit [23:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	// Hold the sender until every result is back, then let the block settle
	task automatic drain_all();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic lsgb_pkg::in_item_t place_at(longint x, longint y, longint z);
		lsgb_pkg::in_item_t req;
		req.action = lsgb_pkg::ACTION_PLACE;
		req.pos_x  = x[31:0];
		req.pos_y  = y[31:0];
		req.pos_z  = z[31:0];
		return req;
	endfunction

	function automatic lsgb_pkg::in_item_t clear_req();
		lsgb_pkg::in_item_t req;
		req        = '0;
		req.action = lsgb_pkg::ACTION_CLEAR;
		req.pos_x  = $urandom;
		req.pos_y  = $urandom;
		req.pos_z  = $urandom;
		return req;
	endfunction

	// Offset in Q16.16 that lands on coordinate c plus a Q.32 fraction
	function automatic longint axis_offset(longint c, bit [23:0] sc, longint frac);
		if (sc == 0)
			return longint'($urandom_range(0, 1 << 29)) - (1 << 28);
		return ((c <<< 32) + frac) / longint'(sc);
	endfunction

	function automatic longint coord_span(bit [23:0] sc);
		return (sc / 4 < 3000) ? sc / 4 : 3000;
	endfunction

	// Build a well-formed site on a free cell, or one carrying the given fault
	function automatic lsgb_pkg::in_item_t next_site(int seq, fault_t fault);
		longint c [3];
		longint frac [3];
		longint span [3];
		longint cell_ix;
		int     tries;
		span[0] = coord_span(sb.scale_xy);
		span[1] = span[0];
		span[2] = coord_span(sb.scale_z);
		if (seq == 0) begin
			gen_origin[0] = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
			gen_origin[1] = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
			gen_origin[2] = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
			c = '{0, 0, 0};
		end else if (fault == FAULT_REPEAT) begin
			c = last_c;
		end else begin
			tries = 0;
			do begin
				for (int a = 0; a < 3; a++)
					c[a] = longint'($urandom_range(0, 2 * span[a])) - span[a];
				c[1] = (c[1] & ~longint'(1)) | (c[0] & 1);
				c[2] = (c[2] & ~longint'(1)) | (c[0] & 1);
				if (span[2] == 0)
					c[2] = 0;
				cell_ix = sb.flat_cell(c[0], c[1], c[2]);
				tries++;
			end while ((cell_ix >= 65536 || gen_used[cell_ix]) && tries < 30);
		end
		if (fault == FAULT_PARITY)
			c[1] = c[1] ^ 1;
		if (fault == FAULT_RANGE)
			c[0] = 40000;
		for (int a = 0; a < 3; a++)
			frac[a] = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
		if (fault == FAULT_OFF_GRID)
			frac[2] = 64'sh6000_0000;
		cell_ix = sb.flat_cell(c[0], c[1], c[2]);
		if (fault == FAULT_NONE && cell_ix < 65536)
			gen_used[cell_ix] = 1'b1;
		last_c = c;
		return place_at(gen_origin[0] + axis_offset(c[0], sb.scale_xy, frac[0]),
			gen_origin[1] + axis_offset(c[1], sb.scale_xy, frac[1]),
			gen_origin[2] + axis_offset(c[2], sb.scale_z, frac[2]));
	endfunction

	localparam int NUM_PHASES = 6;
	localparam int UNIT = 65536;

	initial begin
		bit [23:0] ph_sxy [NUM_PHASES] = '{24'd65536, 24'hFFFFFF, 24'd131072,
			24'd262144, 24'd65536, 24'd50000};
		bit [23:0] ph_sz [NUM_PHASES] = '{24'd65536, 24'd0, 24'd92682,
			24'd262144, 24'd65536, 24'd70000};
		bit [10:0] ph_dx [NUM_PHASES] = '{11'd16, 11'd0, 11'd32, 11'd1024, 11'd1024, 11'd7};
		bit [10:0] ph_dy [NUM_PHASES] = '{11'd16, 11'd1, 11'd32, 11'd64, 11'd1024, 11'd13};
		bit [10:0] ph_dz [NUM_PHASES] = '{11'd16, 11'd1, 11'd64, 11'd1, 11'd1024, 11'd11};
		int        ph_len [NUM_PHASES] = '{400, 40, 400, 350, 60, 480};
		fault_t    ph_fault [NUM_PHASES] = '{FAULT_OFF_GRID, FAULT_REPEAT, FAULT_PARITY,
			FAULT_RANGE, FAULT_REPEAT, FAULT_OFF_GRID};
		lsgb_pkg::in_item_t req;
		bit                 broken;

		sb        = new();
		idle_on   = 1'b1;
		hold_req  = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = lsgb_pkg::CFG_SCALE_IN_PLANE;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme origin, then an offset past the coordinate range
		send_request(place_at(32'h7FFF_FFFF, -64'sh8000_0000, 0));
		send_request(place_at(-64'sh8000_0000, 32'h7FFF_FFFF, 0));
		send_request(place_at(0, 0, 0));
		drain_all();
		// Directed: wraparound collision with the origin cell
		write_reg(lsgb_pkg::CFG_GRID_DIM_X, 24'd16);
		send_request(clear_req());
		send_request(place_at(0, 0, 0));
		send_request(place_at(2 * UNIT, 0, 0));
		send_request(place_at(UNIT + 16383, UNIT - 16384, UNIT));
		send_request(place_at(16 * UNIT, 0, 0));
		send_request(place_at(4 * UNIT, 0, 0));
		// Directed: a half cell lands off grid, past the quarter-cell tolerance
		send_request(clear_req());
		send_request(place_at(5, 5, 5));
		send_request(place_at(5 - UNIT - UNIT / 2, 5 - UNIT, 5 - UNIT));
		// Directed: just past a quarter cell off grid
		send_request(clear_req());
		send_request(place_at(0, 0, 0));
		send_request(place_at(2 * UNIT + 16385, 0, 0));
		drain_all();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(lsgb_pkg::CFG_SCALE_IN_PLANE, ph_sxy[p]);
			write_reg(lsgb_pkg::CFG_SCALE_VERTICAL, ph_sz[p]);
			write_reg(lsgb_pkg::CFG_GRID_DIM_X, {13'd0, ph_dx[p]});
			write_reg(lsgb_pkg::CFG_GRID_DIM_Y, {13'd0, ph_dy[p]});
			write_reg(lsgb_pkg::CFG_GRID_DIM_Z, {13'd0, ph_dz[p]});
			foreach (gen_used[n])
				gen_used[n] = 1'b0;
			idle_on = (p != 2);
			if (p == 3)
				hold_req = 1'b1;
			broken = 1'b0;
			send_request(clear_req());
			for (int s = 0; s < ph_len[p]; s++) begin
				if (broken) begin
					// Random noise: placements at random positions, no clears
					req.action = lsgb_pkg::ACTION_PLACE;
					req.pos_x  = $urandom;
					req.pos_y  = $urandom;
					req.pos_z  = $urandom;
				end else if (s == ph_len[p] * 4 / 5) begin
					req    = next_site(s, ph_fault[p]);
					broken = 1'b1;
				end else begin
					req = next_site(s, FAULT_NONE);
				end
				send_request(req);
			end
			drain_all();
		end

		idle_on = 1'b1;
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/lsgb_pkg.sv
src/lsgb_mod.sv
src/lsgb_occ.sv
src/lattice_site_grid_binner_core.sv
verif/tb_lattice_site_grid_binner_core.sv
